@@ rtl/core/pidsat_pkg.sv @@
`timescale 1ns / 1ps

package pidsat_pkg;

    // Fixed field widths
    localparam int GAIN_W   = 16;
    localparam int DT_W     = 8;
    localparam int POS_W    = 12;
    localparam int ERR_W    = POS_W + 1;
    localparam int DERR_W   = ERR_W + 1;
    localparam int DRIVE_W  = 13;
    localparam int QUO_W    = 12;
    localparam int CNT_W    = 4;
    localparam int MUL_B_W  = GAIN_W + 2;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    localparam logic [QUO_W-1:0] DRIVE_MAX = 12'd4095;

    // Register map (word index)
    localparam logic [2:0] REG_KP_UPPER      = 3'd0;
    localparam logic [2:0] REG_KI_UPPER      = 3'd1;
    localparam logic [2:0] REG_KD_UPPER      = 3'd2;
    localparam logic [2:0] REG_KP_LOWER      = 3'd3;
    localparam logic [2:0] REG_KI_LOWER      = 3'd4;
    localparam logic [2:0] REG_KD_LOWER      = 3'd5;
    localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd6;

    localparam logic [DT_W-1:0] SAMPLE_PERIOD_RST = 8'd10;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_T1A  = 11'b000_0000_0010,
        ST_T1B  = 11'b000_0000_0100,
        ST_T2A  = 11'b000_0000_1000,
        ST_T2B  = 11'b000_0001_0000,
        ST_T2C  = 11'b000_0010_0000,
        ST_T3   = 11'b000_0100_0000,
        ST_SUM  = 11'b000_1000_0000,
        ST_SIGN = 11'b001_0000_0000,
        ST_DIV  = 11'b010_0000_0000,
        ST_FIN  = 11'b100_0000_0000
    } seq_state_t;

endpackage

@@ rtl/core/pid_two_channel_saturating_top.sv @@
`timescale 1ns / 1ps

// Channel  Handshake          Fields
// -------  -----------------  ------------------------------------------------
// in       in_valid/in_stall  channel, target_position, measured_position
// out      out_valid/out_stall drive_value
// cfg      APB write/read     7 registers at byte address 4*i
//
// Each accepted word makes six passes through the shared multiplier, a
// sign/limit check, then a 12-step restoring divide by (dt << GAIN_FRAC_BITS),
// which is skipped when the quotient saturates.
// in_stall is high whenever the sequencer is not idle; a finished result may
// wait in the output register while the next word is accepted.
// Reset clears gains, sample period (to 10), both channel stores and control.
module pid_two_channel_saturating_top
    import pidsat_pkg::*;
#(
    parameter int NUM_CHANNELS   = 2,
    parameter int OUTPUT_LIMIT   = 4095,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      channel,
    input  logic [POS_W-1:0]          target_position,
    input  logic [POS_W-1:0]          measured_position,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DRIVE_W-1:0] drive_value
);

    localparam int ACC_W   = $clog2(OUTPUT_LIMIT + 1) + 1;
    localparam int A_BASE  = (ACC_W > DERR_W) ? ACC_W : DERR_W;
    localparam int A_W     = A_BASE + 2 * DT_W + 1;
    localparam int P_W     = A_W + MUL_B_W;
    localparam int NUM_W   = P_W + 2;
    localparam int DEN_W   = DT_W + GAIN_FRAC_BITS;
    localparam int SLOT_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic signed [ACC_W+1:0] ACC_HI = (ACC_W + 2)'(OUTPUT_LIMIT);
    localparam logic signed [ACC_W+1:0] ACC_LO = -ACC_HI;

    // Configuration registers
    logic signed [GAIN_W-1:0] kp_upper_reg, ki_upper_reg, kd_upper_reg;
    logic signed [GAIN_W-1:0] kp_lower_reg, ki_lower_reg, kd_lower_reg;
    logic [DT_W-1:0]          sample_period_reg;
    logic                     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_upper_reg      <= '0;
            ki_upper_reg      <= '0;
            kd_upper_reg      <= '0;
            kp_lower_reg      <= '0;
            ki_lower_reg      <= '0;
            kd_lower_reg      <= '0;
            sample_period_reg <= SAMPLE_PERIOD_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_KP_UPPER:      kp_upper_reg      <= pwdata[GAIN_W-1:0];
                REG_KI_UPPER:      ki_upper_reg      <= pwdata[GAIN_W-1:0];
                REG_KD_UPPER:      kd_upper_reg      <= pwdata[GAIN_W-1:0];
                REG_KP_LOWER:      kp_lower_reg      <= pwdata[GAIN_W-1:0];
                REG_KI_LOWER:      ki_lower_reg      <= pwdata[GAIN_W-1:0];
                REG_KD_LOWER:      kd_lower_reg      <= pwdata[GAIN_W-1:0];
                REG_SAMPLE_PERIOD: sample_period_reg <= pwdata[DT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_KP_UPPER:      prdata = {{(APB_DW-GAIN_W){1'b0}}, kp_upper_reg};
            REG_KI_UPPER:      prdata = {{(APB_DW-GAIN_W){1'b0}}, ki_upper_reg};
            REG_KD_UPPER:      prdata = {{(APB_DW-GAIN_W){1'b0}}, kd_upper_reg};
            REG_KP_LOWER:      prdata = {{(APB_DW-GAIN_W){1'b0}}, kp_lower_reg};
            REG_KI_LOWER:      prdata = {{(APB_DW-GAIN_W){1'b0}}, ki_lower_reg};
            REG_KD_LOWER:      prdata = {{(APB_DW-GAIN_W){1'b0}}, kd_lower_reg};
            REG_SAMPLE_PERIOD: prdata = {{(APB_DW-DT_W){1'b0}}, sample_period_reg};
            default:           prdata = '0;
        endcase
    end

    // Sequencer and datapath registers
    seq_state_t                state_reg, state_next;
    logic                      ch_reg, ch_next;
    logic signed [ERR_W-1:0]   e_reg, e_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [DERR_W-1:0]  de_reg, de_next;
    logic signed [P_W-1:0]     prod_reg, prod_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic [NUM_W-1:0]          rem_reg, rem_next;
    logic [NUM_W-1:0]          dsh_reg, dsh_next;
    logic [QUO_W-1:0]          quo_reg, quo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      neg_reg, neg_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;

    // Per-channel state
    logic signed [ACC_W-1:0] integral_reg [NUM_CHANNELS];
    logic signed [ERR_W-1:0] last_err_reg [NUM_CHANNELS];
    logic                    st_we;
    logic [SLOT_W-1:0]       slot;

    logic                    in_accept;
    logic signed [ACC_W+1:0] acc_sum;
    logic [DT_W-1:0]         dt;
    logic [DEN_W-1:0]        den;
    logic signed [GAIN_W-1:0] kp_sel, ki_sel, kd_sel;
    logic signed [A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [P_W-1:0]   mul_p;
    logic signed [NUM_W-1:0] num_add;
    logic [NUM_W-1:0]        sat_lim;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign drive_value = drive_reg;

    assign slot = (32'(channel) < NUM_CHANNELS) ? SLOT_W'(channel)
                                                : SLOT_W'(NUM_CHANNELS - 1);
    assign dt   = (sample_period_reg == '0) ? DT_W'(1) : sample_period_reg;
    assign den  = {dt, {GAIN_FRAC_BITS{1'b0}}};

    assign kp_sel = ch_reg ? kp_lower_reg : kp_upper_reg;
    assign ki_sel = ch_reg ? ki_lower_reg : ki_upper_reg;
    assign kd_sel = ch_reg ? kd_lower_reg : kd_upper_reg;

    assign acc_sum = {{2{integral_reg[slot][ACC_W-1]}}, integral_reg[slot]}
                   + {{(ACC_W+2-ERR_W){e_next[ERR_W-1]}}, e_next};

    // Shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_T1A:
            begin
                mul_a = {{(A_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
                mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt};
            end
            ST_T1B:
            begin
                mul_a = prod_reg[A_W-1:0];
                mul_b = {{(MUL_B_W-GAIN_W){kp_sel[GAIN_W-1]}}, kp_sel};
            end
            ST_T2A:
            begin
                mul_a = {{(A_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
                mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt};
            end
            ST_T2B:
            begin
                mul_a = prod_reg[A_W-1:0];
                mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt};
            end
            ST_T2C:
            begin
                mul_a = prod_reg[A_W-1:0];
                mul_b = {{(MUL_B_W-GAIN_W){ki_sel[GAIN_W-1]}}, ki_sel};
            end
            ST_T3:
            begin
                mul_a = {{(A_W-DERR_W){de_reg[DERR_W-1]}}, de_reg};
                mul_b = {{(MUL_B_W-GAIN_W){kd_sel[GAIN_W-1]}}, kd_sel};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign num_add = num_reg + {{(NUM_W-P_W){prod_reg[P_W-1]}}, prod_reg};
    assign sat_lim = NUM_W'(den) << QUO_W;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        e_next         = $signed({1'b0, target_position}) - $signed({1'b0, measured_position});
        acc_next       = acc_reg;
        de_next        = de_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        drive_next     = drive_reg;
        out_valid_next = out_valid_reg && out_stall;
        st_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    ch_next = channel;
                    priority if (acc_sum > ACC_HI)
                        acc_next = ACC_HI[ACC_W-1:0];
                    else if (acc_sum < ACC_LO)
                        acc_next = ACC_LO[ACC_W-1:0];
                    else
                        acc_next = acc_sum[ACC_W-1:0];
                    de_next  = {e_next[ERR_W-1], e_next}
                             - {last_err_reg[slot][ERR_W-1], last_err_reg[slot]};
                    num_next = '0;
                    st_we    = 1'b1;
                    state_next = ST_T1A;
                end
            end
            ST_T1A:
            begin
                prod_next  = mul_p;
                state_next = ST_T1B;
            end
            ST_T1B:
            begin
                prod_next  = mul_p;
                state_next = ST_T2A;
            end
            ST_T2A:
            begin
                num_next   = num_add;
                prod_next  = mul_p;
                state_next = ST_T2B;
            end
            ST_T2B:
            begin
                prod_next  = mul_p;
                state_next = ST_T2C;
            end
            ST_T2C:
            begin
                prod_next  = mul_p;
                state_next = ST_T3;
            end
            ST_T3:
            begin
                num_next   = num_add;
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                num_next   = num_add;
                state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                // work on the magnitude so the quotient truncates toward zero
                neg_next = num_reg[NUM_W-1];
                rem_next = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
                if ((num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg)) >= sat_lim)
                begin
                    quo_next   = DRIVE_MAX;
                    state_next = ST_FIN;
                end
                else
                begin
                    quo_next   = '0;
                    dsh_next   = NUM_W'(den) << (QUO_W - 1);
                    cnt_next   = CNT_W'(QUO_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    drive_next     = neg_reg ? -$signed({1'b0, quo_reg})
                                             : $signed({1'b0, quo_reg});
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                integral_reg[i] <= '0;
                last_err_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (st_we)
            begin
                integral_reg[slot] <= acc_next;
                last_err_reg[slot] <= e_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        e_reg     <= e_next;
        acc_reg   <= acc_next;
        de_reg    <= de_next;
        prod_reg  <= prod_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        drive_reg <= drive_next;
    end

endmodule

@@ tb/pid_two_channel_saturating_top_test.sv @@
`timescale 1ns / 1ps

module pid_two_channel_saturating_top_test;

    import pidsat_pkg::*;

    localparam int          OUT_LIMIT      = 4095;
    localparam int          FRAC_BITS      = 8;
    localparam longint      DRIVE_LIMIT    = 4095;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          RAND_PHASES    = 9;
    localparam int          WORDS_PER_PHASE = 187;
    localparam logic [2:0]  REG_UNUSED     = 3'd7;
    localparam logic        CH_UPPER       = 1'b0;
    localparam logic        CH_LOWER       = 1'b1;
    localparam logic [15:0] GAIN_MAX       = 16'h7FFF;
    localparam logic [15:0] GAIN_MIN       = 16'h8000;

    typedef struct packed {
        logic             ch;
        logic [POS_W-1:0] tgt;
        logic [POS_W-1:0] meas;
    } pid_sample_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_AW-1:0]         paddr = '0;
    logic [APB_DW-1:0]         pwdata = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      channel = 1'b0;
    logic [POS_W-1:0]          target_position = '0;
    logic [POS_W-1:0]          measured_position = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [DRIVE_W-1:0] drive_value;

    // predictor copy of the register file and channel stores
    logic signed [GAIN_W-1:0]  kp_gain [2];
    logic signed [GAIN_W-1:0]  ki_gain [2];
    logic signed [GAIN_W-1:0]  kd_gain [2];
    logic [DT_W-1:0]           loop_period;
    longint                    accum_state [2];
    longint                    prev_error [2];

    pid_sample_t               sample_q [$];
    logic signed [DRIVE_W-1:0] drive_expect_q [$];
    pid_sample_t               staged_sample;
    logic signed [DRIVE_W-1:0] expected_drive;

    int sender_idle_pct = 23;
    int receiver_idle_pct = 54;
    int rx_hold_left = 0;
    bit send_paused = 1'b0;
    int fail_count = 0;
    int quiet_cycles = 0;

    pid_two_channel_saturating_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .channel           (channel),
        .target_position   (target_position),
        .measured_position (measured_position),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .drive_value       (drive_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Advance the channel stores and work out the drive for one word.
    function automatic logic signed [DRIVE_W-1:0] predict_drive(
        input logic ch, input logic [POS_W-1:0] tgt, input logic [POS_W-1:0] meas);
        longint kp, ki, kd, dt, err, acc, derr, num, den, quo;
        kp = kp_gain[ch];
        ki = ki_gain[ch];
        kd = kd_gain[ch];
        dt = (loop_period == '0) ? 64'sd1 : longint'(loop_period);
        err = longint'(tgt) - longint'(meas);
        acc = clamp_sym(accum_state[ch] + err, OUT_LIMIT);
        accum_state[ch] = acc;
        derr = err - prev_error[ch];
        prev_error[ch] = err;
        num = dt * (kp * err) + dt * dt * (ki * acc) + kd * derr;
        den = dt * (64'sd1 <<< FRAC_BITS);
        quo = clamp_sym(num / den, DRIVE_LIMIT);
        return quo[DRIVE_W-1:0];
    endfunction

    function automatic logic [15:0] rand_gain();
        logic [15:0] g;
        case ($urandom_range(3))
            0: g = 16'($urandom());
            1, 2:
            begin
                g = 16'($urandom_range(2048));
                g = g - 16'd1024;
            end
            default:
            begin
                g = 16'($urandom_range(128));
                g = g - 16'd64;
            end
        endcase
        return g;
    endfunction

    function automatic logic [DT_W-1:0] rand_period();
        if ($urandom_range(4) == 0)
            return DT_W'($urandom_range(4, 1));
        return DT_W'($urandom_range(255, 1));
    endfunction

    function automatic pid_sample_t make_sample();
        pid_sample_t s;
        int t, m, off;
        s.ch = 1'($urandom_range(1));
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                s.tgt = POS_W'($urandom());
                s.meas = POS_W'($urandom());
            end
            4, 5, 6:
            begin
                // small error keeps the integral off its limit
                t = $urandom_range(4095);
                off = $urandom_range(80);
                m = t + off - 40;
                if (m < 0)
                    m = 0;
                if (m > 4095)
                    m = 4095;
                s.tgt = POS_W'(t);
                s.meas = POS_W'(m);
            end
            7, 8:
            begin
                s.tgt = POS_W'($urandom_range(4095, 2048));
                s.meas = POS_W'($urandom_range(2047));
            end
            default:
            begin
                s.tgt = POS_W'($urandom_range(2047));
                s.meas = POS_W'($urandom_range(4095, 2048));
            end
        endcase
        return s;
    endfunction

    task automatic push_sample(input logic ch, input int tgt, input int meas);
        pid_sample_t s;
        s.ch = ch;
        s.tgt = POS_W'(tgt);
        s.meas = POS_W'(meas);
        sample_q.push_back(s);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        logic [APB_DW-1:0] word;
        word = $urandom();
        word[15:0] = val;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KP_UPPER:      kp_gain[CH_UPPER] = val;
            REG_KI_UPPER:      ki_gain[CH_UPPER] = val;
            REG_KD_UPPER:      kd_gain[CH_UPPER] = val;
            REG_KP_LOWER:      kp_gain[CH_LOWER] = val;
            REG_KI_LOWER:      ki_gain[CH_LOWER] = val;
            REG_KD_LOWER:      kd_gain[CH_LOWER] = val;
            REG_SAMPLE_PERIOD: loop_period = val[DT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure_all(input logic [15:0] kpu, input logic [15:0] kiu,
                                 input logic [15:0] kdu, input logic [15:0] kpl,
                                 input logic [15:0] kil, input logic [15:0] kdl,
                                 input logic [DT_W-1:0] dt);
        write_reg(REG_KP_UPPER, kpu);
        write_reg(REG_KI_UPPER, kiu);
        write_reg(REG_KD_UPPER, kdu);
        write_reg(REG_KP_LOWER, kpl);
        write_reg(REG_KI_LOWER, kil);
        write_reg(REG_KD_LOWER, kdl);
        write_reg(REG_SAMPLE_PERIOD, {8'h00, dt});
    endtask

    // Hold until every word is sent and answered, then let the pipeline settle.
    task automatic wait_drained();
        while (sample_q.size() != 0 || in_valid || drive_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                drive_expect_q.push_back(
                    predict_drive(channel, target_position, measured_position));
            if (!in_valid || !in_stall)
            begin
                if (sample_q.size() != 0 && !send_paused &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    staged_sample = sample_q.pop_front();
                    channel <= staged_sample.ch;
                    target_position <= staged_sample.tgt;
                    measured_position <= staged_sample.meas;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    report_failure($sformatf("unexpected drive word %0d", drive_value));
                end
                else
                begin
                    expected_drive = drive_expect_q.pop_front();
                    if (drive_value !== expected_drive)
                        report_failure($sformatf("drive_value expected %0d got %0d",
                                                 expected_drive, drive_value));
                end
            end
            if (rx_hold_left > 0)
            begin
                out_stall <= 1'b1;
                rx_hold_left <= rx_hold_left - 1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < receiver_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        kp_gain = '{default: '0};
        ki_gain = '{default: '0};
        kd_gain = '{default: '0};
        loop_period = SAMPLE_PERIOD_RST;
        accum_state = '{default: 0};
        prev_error = '{default: 0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset gains give zero drive but still advance the stores
        push_sample(CH_UPPER, 100, 50);
        push_sample(CH_LOWER, 0, 4095);
        wait_drained();

        configure_all(16'd256, 16'd16, 16'hFF00, 16'hFF80, 16'hFFFF, GAIN_MAX, 8'd1);
        write_reg(REG_UNUSED, 16'hFFFF);
        @(negedge clk);
        // drive the integrals into their limits both ways
        repeat (3) push_sample(CH_UPPER, 4095, 0);
        repeat (3) push_sample(CH_LOWER, 0, 4095);
        push_sample(CH_UPPER, 0, 4095);
        push_sample(CH_LOWER, 4095, 0);
        push_sample(CH_UPPER, 0, 0);
        push_sample(CH_LOWER, 4095, 4095);
        push_sample(CH_UPPER, 2048, 2047);
        push_sample(CH_LOWER, 1, 0);
        wait_drained();

        // zero period falls back to one
        configure_all(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, 8'd0);
        @(negedge clk);
        push_sample(CH_UPPER, 4095, 0);
        push_sample(CH_LOWER, 0, 4095);
        push_sample(CH_UPPER, 0, 0);
        push_sample(CH_LOWER, 10, 20);
        wait_drained();

        configure_all(GAIN_MAX, 16'd1, 16'd512, 16'd3, GAIN_MAX, 16'hFFF0, 8'd255);
        @(negedge clk);
        push_sample(CH_UPPER, 3, 0);
        push_sample(CH_LOWER, 0, 5);
        push_sample(CH_UPPER, 4095, 0);
        push_sample(CH_LOWER, 0, 4095);

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                2: configure_all(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
                                 GAIN_MAX, 8'd255);
                4: configure_all(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN,
                                 GAIN_MIN, 8'd1);
                6: configure_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                                 rand_gain(), rand_gain(), 8'd0);
                default: configure_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                                       rand_gain(), rand_gain(), rand_period());
            endcase
            @(negedge clk);
            case (ph / 3)
                0:
                begin
                    sender_idle_pct = 23;
                    receiver_idle_pct = 54;
                end
                1:
                begin
                    sender_idle_pct = 54;
                    receiver_idle_pct = 23;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                sample_q.push_back(make_sample());
            if (ph == 0)
            begin
                // back up the output so the block stalls its input
                while (sample_q.size() > 120)
                    @(negedge clk);
                rx_hold_left = 300;
            end
            if (ph == 4)
            begin
                while (sample_q.size() > 90)
                    @(negedge clk);
                send_paused = 1'b1;
                while (in_valid || drive_expect_q.size() != 0)
                    @(negedge clk);
                send_paused = 1'b0;
            end
        end

        wait_drained();
        if (drive_expect_q.size() != 0)
            report_failure($sformatf("%0d drive words never arrived", drive_expect_q.size()));
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ pid_two_channel_saturating_top.f @@
rtl/core/pidsat_pkg.sv
rtl/core/pid_two_channel_saturating_top.sv
tb/pid_two_channel_saturating_top_test.sv
